### src/gn2d_pkg.sv
// gn2d_pkg: shared types and constants of the 2D gradient noise core.
// Holds the gradient ROM contents (built from a fixed integer series),
// output saturation limits, action codes and the stage enable struct.
package gn2d_pkg;

  localparam logic ACT_EVAL = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam int NOISE_W   = 19;
  localparam int NOISE_MAX = 262143;
  localparam int NOISE_MIN = -262144;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [31:0] grad_rom_t [256];

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // divide one series term by (k+1)(k+2) for step n
  function automatic logic [63:0] series_div(logic [63:0] t, logic odd, int n);
    logic [63:0] r;
    case (n)
      1: r = odd ? t / 64'd6   : t / 64'd2;
      2: r = odd ? t / 64'd20  : t / 64'd12;
      3: r = odd ? t / 64'd42  : t / 64'd30;
      4: r = odd ? t / 64'd72  : t / 64'd56;
      5: r = odd ? t / 64'd110 : t / 64'd90;
      6: r = odd ? t / 64'd156 : t / 64'd132;
      7: r = odd ? t / 64'd210 : t / 64'd182;
      default: r = t;
    endcase
    return r;
  endfunction

  // sin (odd) or cos (even) of Q30 angle in first quadrant, result Q1.15
  function automatic logic [15:0] series_q15(logic [63:0] a, logic odd);
    logic [63:0] term;
    longint      sum;
    term = odd ? a : (64'd1 << 30);
    sum  = longint'(term);
    for (int n = 1; n <= 7; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = series_div(term, odd, n);
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return 16'(sum);
  endfunction

  function automatic grad_rom_t build_grad_rom();
    grad_rom_t   rom;
    logic [63:0] a;
    logic [15:0] c;
    logic [15:0] s;
    logic [15:0] cv;
    logic [15:0] sv;
    for (int i = 0; i < 256; i++) begin
      a = (PI_Q30 * 64'(i % 64)) >> 7;
      c = series_q15(a, 1'b0);
      s = series_q15(a, 1'b1);
      case (i / 64)
        0: begin cv = c;  sv = s;  end
        1: begin cv = -s; sv = c;  end
        2: begin cv = -c; sv = -s; end
        default: begin cv = s; sv = -c; end
      endcase
      rom[i] = {sv, cv};
    end
    return rom;
  endfunction

  localparam grad_rom_t GRAD_ROM = build_grad_rom();

endpackage

### src/gn2d_ram.sv
// gn2d_ram: generic synchronous RAM, one write port, two registered read ports.
// Read-first: a read of the address written in the same cycle returns old data.
// No dependencies.
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

### src/gn2d_fade.sv
// gn2d_fade: three-stage fade pipeline, fade = e^3*(6e^2 - 15e + 10), e in Q(F).
// Depends on gn2d_pkg (stage_en_t).
module gn2d_fade import gn2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic [FRAC_BITS:0]   e_in,
  output logic [FRAC_BITS:0]   fade_out
);

  localparam int F  = FRAC_BITS;
  localparam int PW = F + 5;

  logic [2*F+1:0] ee;
  logic [2*F+1:0] e3_full;
  logic [2*F+5:0] fp_full;
  logic [PW-1:0]  p_pos;
  logic [PW-1:0]  p_neg;
  logic [PW-1:0]  p_cl;

  logic [F:0]     e_s2_r;
  logic [F:0]     e2_s2_r;
  logic [F:0]     e3_s3_r;
  logic [PW-1:0]  p_s3_r;
  logic [F:0]     fade_s4_r;

  assign ee      = e_in * e_in;
  assign e3_full = e2_s2_r * e_s2_r;
  // 6*e2 + 10*one against 15*e; clamp at zero
  assign p_pos   = (PW'(e2_s2_r) << 2) + (PW'(e2_s2_r) << 1)
                 + (PW'(1) << (F + 3)) + (PW'(1) << (F + 1));
  assign p_neg   = (PW'(e_s2_r) << 4) - PW'(e_s2_r);
  assign p_cl    = (p_pos >= p_neg) ? (p_pos - p_neg) : '0;
  assign fp_full = e3_s3_r * p_s3_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      e_s2_r  <= e_in;
      e2_s2_r <= ee[2*F:F];
    end
    if (en.s3) begin
      e3_s3_r <= e3_full[2*F:F];
      p_s3_r  <= p_cl;
    end
    if (en.s4) begin
      fade_s4_r <= fp_full[2*F:F];
    end
  end

  assign fade_out = fade_s4_r;

endmodule

### src/gradient_noise_2d_core.sv
// gradient_noise_2d_core: 2D gradient noise, seven-stage pipeline.
// Uses gn2d_pkg, gn2d_ram (three copies of the permutation table), gn2d_fade.
//
//  channel | ports                                   | role
//  in      | in_valid/in_ready, in_action, in_x_pos, | evaluate point or load one
//          | in_y_pos, in_table_index, in_table_value| permutation entry
//  out     | out_valid/out_ready, out_noise_value    | Q2.16 noise, saturated
//
// One beat per cycle is taken while in_ready is high; an eval result leaves at stage 7.
// A load beat writes the permutation copies in the cycle it is taken, no result.
// Hash reads use three RAM copies: one for perm[x], two for the second level.
// Reset clears only pipeline valid bits; the table is undefined until loaded.
// A stall at out holds each full stage; empty stages keep filling.
module gradient_noise_2d_core import gn2d_pkg::*; #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [31:0]               in_x_pos,
  input  logic [31:0]               in_y_pos,
  input  logic [7:0]                in_table_index,
  input  logic [7:0]                in_table_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [NOISE_W-1:0] out_noise_value
);

  localparam int F     = FRAC_BITS;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PW    = F + 18;
  localparam int DW    = F + 19;
  localparam int QW    = F + 4;
  localparam int SFW   = F + 6;
  localparam int SUMW  = F + 8;
  localparam int SW    = F + 24;
  localparam int SHR   = (F >= 16) ? F - 16 : 0;
  localparam int SHL   = (F < 16) ? 16 - F : 0;

  localparam logic [F:0]          ONE_U  = (F + 1)'(1) << F;
  localparam logic signed [F+1:0] ONE_S  = (F + 2)'(1) << F;
  localparam logic signed [SW-1:0] SAT_HI = SW'(NOISE_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(NOISE_MIN);

  // stage enables: a stage loads when empty or when the next one loads
  logic en1, en2, en3, en4, en5, en6, en7;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  assign en7 = !out_valid_r || out_ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  logic in_acc;
  logic load_wr;
  logic eval_acc;
  assign in_acc   = in_valid && in_ready;
  assign load_wr  = in_acc && (in_action == ACT_LOAD);
  assign eval_acc = in_acc && (in_action == ACT_EVAL);

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] xi0;
  logic [IDX_W-1:0] xi1;
  logic [IDX_W-1:0] yi0;
  logic [F-1:0]     fx0;
  logic [F-1:0]     fy0;

  assign wr_idx = IDX_W'(32'(in_table_index));
  assign xi0    = IDX_W'(in_x_pos >> F);
  assign xi1    = xi0 + IDX_W'(1);
  assign yi0    = IDX_W'(in_y_pos >> F);
  assign fx0    = in_x_pos[F-1:0];
  assign fy0    = in_y_pos[F-1:0];

  // ---- stage 1: perm[x], perm[x+1] read; fade inputs
  logic [F-1:0]     fx1_r, fy1_r;
  logic [IDX_W-1:0] yi1_r;
  logic [F:0]       e1_r [4];
  logic [7:0]       h_x0, h_x1;

  gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_x (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (wr_idx),
    .wr_data   (in_table_value),
    .rd_en     (en1),
    .rd_addr_a (xi0),
    .rd_addr_b (xi1),
    .rd_data_a (h_x0),
    .rd_data_b (h_x1)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      fx1_r   <= fx0;
      fy1_r   <= fy0;
      yi1_r   <= yi0;
      e1_r[0] <= ONE_U - (F + 1)'(fx0);
      e1_r[1] <= (F + 1)'(fx0);
      e1_r[2] <= ONE_U - (F + 1)'(fy0);
      e1_r[3] <= (F + 1)'(fy0);
    end
  end

  // ---- stage 2: second hash level, corner order 00, 10, 01, 11
  logic [IDX_W-1:0] a_l0, a_l1, a_r0, a_r1;
  logic [7:0]       h_c [4];
  logic [F-1:0]     fx2_r, fy2_r;

  assign a_l0 = IDX_W'(h_x0) + yi1_r;
  assign a_l1 = a_l0 + IDX_W'(1);
  assign a_r0 = IDX_W'(h_x1) + yi1_r;
  assign a_r1 = a_r0 + IDX_W'(1);

  gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_l (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (wr_idx),
    .wr_data   (in_table_value),
    .rd_en     (en2),
    .rd_addr_a (a_l0),
    .rd_addr_b (a_l1),
    .rd_data_a (h_c[0]),
    .rd_data_b (h_c[2])
  );

  gn2d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_r (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (wr_idx),
    .wr_data   (in_table_value),
    .rd_en     (en2),
    .rd_addr_a (a_r0),
    .rd_addr_b (a_r1),
    .rd_data_a (h_c[1]),
    .rd_data_b (h_c[3])
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
    end
  end

  // fade units: x left, x right, y low, y high
  stage_en_t  fen;
  logic [F:0] fade_v [4];
  assign fen = '{s2: en2, s3: en3, s4: en4};

  for (genvar k = 0; k < 4; k++) begin : g_fade
    gn2d_fade #(.FRAC_BITS(F)) u_fade (
      .clk      (clk),
      .en       (fen),
      .e_in     (e1_r[k]),
      .fade_out (fade_v[k])
    );
  end

  // ---- stage 3: gradient products
  logic signed [F+1:0] dx_s [2];
  logic signed [F+1:0] dy_s [2];
  logic signed [PW-1:0] pc [4];
  logic signed [PW-1:0] ps [4];
  logic signed [PW-1:0] pc3_r [4];
  logic signed [PW-1:0] ps3_r [4];

  assign dx_s[0] = $signed({2'b00, fx2_r});
  assign dx_s[1] = $signed({2'b00, fx2_r}) - ONE_S;
  assign dy_s[0] = $signed({2'b00, fy2_r});
  assign dy_s[1] = $signed({2'b00, fy2_r}) - ONE_S;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pc[c] = $signed(GRAD_ROM[h_c[c]][15:0]) * dx_s[c % 2];
      ps[c] = $signed(GRAD_ROM[h_c[c]][31:16]) * dy_s[c / 2];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int c = 0; c < 4; c++) begin
        pc3_r[c] <= pc[c];
        ps3_r[c] <= ps[c];
      end
    end
  end

  // ---- stage 4: dot >> 15
  logic signed [DW-1:0] dot [4];
  logic signed [QW-1:0] dq4_r [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dot[c] = DW'(pc3_r[c]) + DW'(ps3_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int c = 0; c < 4; c++) begin
        dq4_r[c] <= QW'(dot[c] >>> 15);
      end
    end
  end

  // ---- stage 5: weights
  logic [2*F+1:0]       wp [4];
  logic [F:0]           w5_r [4];
  logic signed [QW-1:0] dq5_r [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      wp[c] = fade_v[c % 2] * fade_v[2 + c / 2];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int c = 0; c < 4; c++) begin
        w5_r[c]  <= wp[c][2*F:F];
        dq5_r[c] <= dq4_r[c];
      end
    end
  end

  // ---- stage 6: surflets
  logic signed [2*F+5:0] sp [4];
  logic signed [SFW-1:0] sf6_r [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sp[c] = $signed({1'b0, w5_r[c]}) * dq5_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int c = 0; c < 4; c++) begin
        sf6_r[c] <= SFW'(sp[c] >>> F);
      end
    end
  end

  // ---- stage 7: sum, rescale to Q16, saturate
  logic signed [SUMW-1:0]    sum;
  logic signed [SW-1:0]      scaled;
  logic signed [NOISE_W-1:0] sat;
  logic signed [NOISE_W-1:0] out_noise_r;

  assign sum    = SUMW'(sf6_r[0]) + SUMW'(sf6_r[1]) + SUMW'(sf6_r[2]) + SUMW'(sf6_r[3]);
  assign scaled = (SW'(sum) <<< SHL) >>> SHR;

  always_comb begin
    if (scaled > SAT_HI) sat = NOISE_W'(SAT_HI);
    else if (scaled < SAT_LO) sat = NOISE_W'(SAT_LO);
    else sat = NOISE_W'(scaled);
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      out_noise_r <= sat;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= eval_acc;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) out_valid_r <= v6_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule
